### hw/rtl/tfu_pkg.sv
// Package for the texel format unpacker: format codes, sizes, register indexes.
`default_nettype none
package tfu_pkg;
	localparam int CountBits = 29;

	typedef enum logic [4:0] {
		FMT_ALPHA8 = 5'd0, FMT_ARGB4444 = 5'd1, FMT_RGB24 = 5'd2, FMT_RGBA32 = 5'd3,
		FMT_ARGB32 = 5'd4, FMT_RGB565 = 5'd5, FMT_R16 = 5'd6, FMT_RGBA4444 = 5'd7,
		FMT_BGRA32 = 5'd8, FMT_RHALF = 5'd9, FMT_RGHALF = 5'd10, FMT_RGBAHALF = 5'd11,
		FMT_RFLOAT = 5'd12, FMT_RGFLOAT = 5'd13, FMT_RGBAFLOAT = 5'd14,
		FMT_RGB9E5 = 5'd15, FMT_RG16 = 5'd16, FMT_R8 = 5'd17
	} fmt_t;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_ENDIAN = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	// bytes per pixel minus one; unknown codes count as one byte
	function automatic logic [3:0] last_slot(input logic [4:0] f);
		logic [3:0] r;
		unique case (f)
			FMT_ALPHA8, FMT_R8: r = 4'd0;
			FMT_ARGB4444, FMT_RGB565, FMT_R16, FMT_RGBA4444, FMT_RHALF, FMT_RG16: r = 4'd1;
			FMT_RGB24: r = 4'd2;
			FMT_RGBA32, FMT_ARGB32, FMT_BGRA32, FMT_RGHALF, FMT_RFLOAT, FMT_RGB9E5: r = 4'd3;
			FMT_RGBAHALF, FMT_RGFLOAT: r = 4'd7;
			FMT_RGBAFLOAT: r = 4'd15;
			default: r = 4'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/tfu_f2b.sv
// Float32 channel to byte: clamp to 0..1, round as fl(fl(v*255)+0.5), truncate.
`default_nettype none
module tfu_f2b (
	input  wire logic [31:0] bits,
	output logic      [7:0]  byte_out
);
	logic [7:0]  ex;
	logic [23:0] m;
	logic [31:0] p;
	logic [23:0] pr;
	logic [4:0]  ep;
	logic [63:0] q;
	logic [7:0]  qr;
	logic        lsb, rbit, sticky;

	always_comb begin
		ex = bits[30:23];
		m = {1'b1, bits[22:0]};
		p = 32'(m) * 32'd255;
		// p has 31 or 32 bits; round to 24 significant bits
		if (p[31]) begin
			lsb = p[8]; rbit = p[7]; sticky = |p[6:0];
			pr = p[31:8] + 24'((rbit && (sticky || lsb)) ? 1 : 0);
			ep = 5'd8;
		end else begin
			lsb = p[7]; rbit = p[6]; sticky = |p[5:0];
			pr = p[30:7] + 24'((rbit && (sticky || lsb)) ? 1 : 0);
			ep = 5'd7;
		end
		// value = pr * 2^(ep + ex - 150); place in units of 2^-35
		q = (64'(pr) << (ep + 5'(ex - 8'd115))) + (64'd1 << 34);
		// q < 2^43: result is q rounded to 24 significant bits, then >> 35
		qr = 8'(q >> 35);
		if (q[42]) begin
			if (q[18] && ((|q[17:0]) || q[19])) qr = 8'((q + (64'd1 << 19)) >> 35);
		end else if (q[41]) begin
			if (q[17] && ((|q[16:0]) || q[18])) qr = 8'((q + (64'd1 << 18)) >> 35);
		end else if (q[40]) begin
			if (q[16] && ((|q[15:0]) || q[17])) qr = 8'((q + (64'd1 << 17)) >> 35);
		end else if (q[39]) begin
			if (q[15] && ((|q[14:0]) || q[16])) qr = 8'((q + (64'd1 << 16)) >> 35);
		end else if (q[38]) begin
			if (q[14] && ((|q[13:0]) || q[15])) qr = 8'((q + (64'd1 << 15)) >> 35);
		end else if (q[37]) begin
			if (q[13] && ((|q[12:0]) || q[14])) qr = 8'((q + (64'd1 << 14)) >> 35);
		end else if (q[36]) begin
			if (q[12] && ((|q[11:0]) || q[13])) qr = 8'((q + (64'd1 << 13)) >> 35);
		end else if (q[35]) begin
			if (q[11] && ((|q[10:0]) || q[12])) qr = 8'((q + (64'd1 << 12)) >> 35);
		end else begin
			if (q[10] && ((|q[9:0]) || q[11])) qr = 8'((q + (64'd1 << 11)) >> 35);
		end
		if (bits[31]) byte_out = 8'd0;
		else if (ex == 8'hFF) byte_out = (bits[22:0] != 23'd0) ? 8'd0 : 8'd255;
		else if (ex >= 8'd127) byte_out = 8'd255;
		else if (ex < 8'd115) byte_out = 8'd0;
		else byte_out = qr;
	end
endmodule
`default_nettype wire

### hw/rtl/tfu_decode.sv
// Pixel decode from gathered bytes to ARGB8888.
`default_nettype none
module tfu_decode (
	input  wire logic [127:0] pix,
	input  wire logic [4:0]   fmt,
	input  wire logic         be,
	output logic      [31:0]  argb
);
	logic [31:0] fin [4];
	logic [7:0]  fout [4];
	logic [15:0] w16 [8];
	logic [31:0] w32 [4];
	logic [7:0]  b [16];
	logic [31:0] v;
	logic [4:0]  ee;

	function automatic logic [31:0] h2f(input logic [15:0] h);
		logic [31:0] f;
		logic [3:0]  t;
		f = {h[15], 31'd0};
		if (h[14:10] == 5'h1F) f = {h[15], 8'hFF, h[9:0], 13'd0};
		else if (h[14:10] != 5'd0) f = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
		else if (h[9:0] != 10'd0) begin
			t = 4'd0;
			for (int i = 0; i < 10; i++) if (h[i]) t = 4'(i);
			f = {h[15], 8'(t) + 8'd103, 23'((23'(h[9:0]) << (5'd23 - 5'(t))))};
		end
		return f;
	endfunction

	function automatic logic [31:0] e5f(input logic [8:0] m, input logic [4:0] e);
		logic [3:0] t;
		logic [31:0] f;
		t = 4'd0;
		for (int i = 0; i < 9; i++) if (m[i]) t = 4'(i);
		f = {1'b0, 8'(t) + 8'(e) + 8'd103, 23'((23'(m) << (5'd23 - 5'(t))))};
		if (m == 9'd0) f = 32'd0;
		return f;
	endfunction

	function automatic logic [7:0] x4(input logic [3:0] n);
		return {n, n};
	endfunction

	for (genvar k = 0; k < 4; k++) begin : g_f
		tfu_f2b u_f2b (.bits(fin[k]), .byte_out(fout[k]));
	end

	always_comb begin
		for (int i = 0; i < 16; i++) b[i] = pix[8*i +: 8];
		for (int i = 0; i < 8; i++)
			w16[i] = be ? {b[2*i], b[2*i+1]} : {b[2*i+1], b[2*i]};
		for (int i = 0; i < 4; i++)
			w32[i] = be ? {w16[2*i], w16[2*i+1]} : {w16[2*i+1], w16[2*i]};
		v = w32[0];
		ee = v[31:27];
		for (int i = 0; i < 4; i++) fin[i] = 32'd0;
		unique case (fmt)
			tfu_pkg::FMT_RHALF: fin[0] = h2f(w16[0]);
			tfu_pkg::FMT_RGHALF: begin fin[0] = h2f(w16[0]); fin[1] = h2f(w16[1]); end
			tfu_pkg::FMT_RGBAHALF:
				for (int i = 0; i < 4; i++) fin[i] = h2f(w16[i]);
			tfu_pkg::FMT_RFLOAT: fin[0] = w32[0];
			tfu_pkg::FMT_RGFLOAT: begin fin[0] = w32[0]; fin[1] = w32[1]; end
			tfu_pkg::FMT_RGBAFLOAT:
				for (int i = 0; i < 4; i++) fin[i] = w32[i];
			tfu_pkg::FMT_RGB9E5: begin
				fin[0] = e5f(v[8:0], ee);
				fin[1] = e5f(v[17:9], ee);
				fin[2] = e5f(v[26:18], ee);
			end
			default: ;
		endcase
		unique case (fmt)
			tfu_pkg::FMT_ALPHA8: argb = {8'hFF, b[0], b[0], b[0]};
			tfu_pkg::FMT_ARGB4444: argb = {x4(w16[0][15:12]), x4(w16[0][11:8]),
				x4(w16[0][7:4]), x4(w16[0][3:0])};
			tfu_pkg::FMT_RGB24: argb = {8'hFF, b[0], b[1], b[2]};
			tfu_pkg::FMT_RGBA32: argb = {b[3], b[0], b[1], b[2]};
			tfu_pkg::FMT_ARGB32: argb = {b[0], b[1], b[2], b[3]};
			tfu_pkg::FMT_RGB565: argb = {8'hFF, w16[0][15:11], w16[0][15:13],
				w16[0][10:5], w16[0][10:9], w16[0][4:0], w16[0][4:2]};
			tfu_pkg::FMT_R16: argb = {8'hFF, w16[0][15:8], w16[0][15:8], w16[0][15:8]};
			tfu_pkg::FMT_RGBA4444: argb = {x4(w16[0][3:0]), x4(w16[0][15:12]),
				x4(w16[0][11:8]), x4(w16[0][7:4])};
			tfu_pkg::FMT_BGRA32: argb = {b[3], b[2], b[1], b[0]};
			tfu_pkg::FMT_RHALF, tfu_pkg::FMT_RFLOAT:
				argb = {8'hFF, fout[0], fout[0], fout[0]};
			tfu_pkg::FMT_RGHALF, tfu_pkg::FMT_RGFLOAT:
				argb = {8'hFF, fout[0], fout[1], 8'd0};
			tfu_pkg::FMT_RGBAHALF, tfu_pkg::FMT_RGBAFLOAT:
				argb = {fout[3], fout[0], fout[1], fout[2]};
			tfu_pkg::FMT_RGB9E5: argb = {8'hFF, fout[0], fout[1], fout[2]};
			tfu_pkg::FMT_RG16: argb = {8'hFF, b[0], b[1], 8'd0};
			default: argb = {8'hFF, b[0], 16'd0};
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/texel_format_unpacker.sv
// Top level of the texel format unpacker.
// m_axis_tvalid follows a pixel's last byte through the pixel and result registers.
// Throughput: one byte per cycle; the pixel register and the result register advance
// whenever the result register is empty or m_axis_tready is high, so full rate runs
// while tready stays high.
// Reset: asynchronous, clears configuration, byte position, pixel count and valid flags.
`default_nettype none
module texel_format_unpacker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [28:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // first_of_texture
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // argb
	output logic             m_axis_tlast   // final_pixel
);
	logic [4:0]   fmt_q;
	logic         be_q;
	logic [28:0]  limit_q;
	logic [7:0]   bytes_q [16];
	logic [3:0]   pos_q;
	logic [28:0]  done_q;
	logic         v_s1, last_s1, be_s1;
	logic [4:0]   fmt_s1;
	logic [127:0] pix_s1;
	logic [31:0]  argb;
	logic         adv1, acc;
	logic [3:0]   pos_n;
	logic [28:0]  done_n;
	logic         full, emit;

	assign adv1 = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv1;
	assign acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		pos_n = s_axis_tuser ? 4'd0 : pos_q;
		done_n = s_axis_tuser ? 29'd0 : done_q;
		full = pos_n >= tfu_pkg::last_slot(fmt_q);
		emit = full && fmt_q < 5'd18 && done_n < limit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 5'd0; be_q <= 1'b0; limit_q <= 29'd0;
			pos_q <= 4'd0; done_q <= 29'd0; v_s1 <= 1'b0; m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tfu_pkg::REG_FORMAT: fmt_q <= cfg_data[4:0];
					tfu_pkg::REG_ENDIAN: be_q <= cfg_data[0];
					tfu_pkg::REG_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				pos_q <= full ? 4'd0 : pos_n + 4'd1;
				done_q <= emit ? done_n + 29'd1 : done_n;
			end
			if (s_axis_tready) v_s1 <= acc && emit;
			if (adv1) m_axis_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) bytes_q[pos_n] <= s_axis_tdata;
		if (acc && emit) begin
			for (int i = 0; i < 16; i++)
				pix_s1[8*i +: 8] <= (4'(i) == pos_n) ? s_axis_tdata : bytes_q[i];
			fmt_s1 <= fmt_q;
			be_s1 <= be_q;
			last_s1 <= (done_n + 29'd1) == limit_q;
		end
		if (adv1 && v_s1) begin
			m_axis_tdata <= argb;
			m_axis_tlast <= last_s1;
		end
	end

	tfu_decode u_decode (.pix(pix_s1), .fmt(fmt_s1), .be(be_s1), .argb(argb));
endmodule
`default_nettype wire
